[hdl/r2y_pkg.sv]
// shared types and constants for the rgb to yuv 4:2:0 converter
// no dependencies

package r2y_pkg;

   // frame geometry
   localparam int MaxWidth  = 4096;
   localparam int MaxHeight = 4096;
   localparam int SizeBits  = 13;   // holds 1..MaxWidth and the register field
   localparam int ColBits   = 13;   // column counter may sit at the width itself
   localparam int RowBits   = 12;   // row counter always below the height

   localparam logic [SizeBits-1:0] SizeMaxW   = SizeBits'(MaxWidth);
   localparam logic [SizeBits-1:0] SizeMaxH   = SizeBits'(MaxHeight);
   localparam logic [SizeBits-1:0] WidthReset  = SizeBits'(640);
   localparam logic [SizeBits-1:0] HeightReset = SizeBits'(480);

   // register map
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 32;
   localparam logic CsrFrameWidth  = 1'b0;
   localparam logic CsrFrameHeight = 1'b1;

   // q16 coefficients
   localparam int CoefBits = 16;
   localparam logic [CoefBits-1:0] KyR = 16'd19595;
   localparam logic [CoefBits-1:0] KyG = 16'd38470;
   localparam logic [CoefBits-1:0] KyB = 16'd7471;
   localparam logic [CoefBits-1:0] KuR = 16'd11076;
   localparam logic [CoefBits-1:0] KuG = 16'd21692;
   localparam logic [CoefBits-1:0] KuB = 16'd32768;
   localparam logic [CoefBits-1:0] KvR = 16'd32768;
   localparam logic [CoefBits-1:0] KvG = 16'd27460;
   localparam logic [CoefBits-1:0] KvB = 16'd5308;
   localparam int ProdBits = CoefBits + 8;
   localparam int SumBits  = ProdBits + 2;
   localparam logic signed [SumBits-1:0] ChromaOfs = SumBits'(128 * 65536);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic       chroma_valid;
      logic       frame_end;
   } rsp_beat_type;

   typedef struct packed {
      logic chroma_valid;
      logic frame_end;
   } pos_flags_type;

endpackage

[hdl/r2y_position.sv]
// raster position tracker: column and row counters, chroma and frame-end flags
// depends on r2y_pkg

module r2y_position
   import r2y_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [SizeBits-1:0] frame_width,
   input  logic [SizeBits-1:0] frame_height,
   output pos_flags_type       flags
);

   logic [ColBits-1:0] col_ff, col_in;
   logic [RowBits-1:0] row_ff, row_in;
   logic [SizeBits-1:0] width_eff, height_eff;
   logic               col_wrap;
   logic [ColBits-1:0] col_now;
   logic [RowBits:0]   row_step;
   logic [RowBits-1:0] row_now;

   always_comb begin
      // clamp sizes to 1..max
      if (frame_width == '0) begin
         width_eff = SizeBits'(1);
      end else if (frame_width > SizeMaxW) begin
         width_eff = SizeMaxW;
      end else begin
         width_eff = frame_width;
      end
      if (frame_height == '0) begin
         height_eff = SizeBits'(1);
      end else if (frame_height > SizeMaxH) begin
         height_eff = SizeMaxH;
      end else begin
         height_eff = frame_height;
      end

      col_wrap = (SizeBits'(col_ff) >= width_eff);
      col_now  = col_wrap ? '0 : col_ff;
      row_step = {1'b0, row_ff} + (RowBits+1)'(col_wrap);
      row_now  = (SizeBits'(row_step) >= height_eff) ? '0 : row_step[RowBits-1:0];

      flags.chroma_valid = ~col_now[0] & ~row_now[0];
      flags.frame_end    = (SizeBits'(col_now) == width_eff - SizeBits'(1)) &&
                           (SizeBits'(row_now) == height_eff - SizeBits'(1));

      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         col_in = col_now + ColBits'(1);
         row_in = row_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

[hdl/r2y_matrix.sv]
// color matrix: q16 products and sums with floor and saturation, one combinational pass
// depends on r2y_pkg

module r2y_matrix
   import r2y_pkg::*;
(
   input  req_beat_type pixel,
   output logic [7:0]   luma,
   output logic [7:0]   chroma_u,
   output logic [7:0]   chroma_v
);

   logic [ProdBits-1:0] yr, yg, yb, ur, ug, ub, vr, vg, vb;
   logic signed [SumBits-1:0] y_sum, u_sum, v_sum;

   function automatic logic [7:0] to_byte(input logic signed [SumBits-1:0] s);
      logic [7:0] result;
      if (s < 0) begin
         result = 8'd0;
      end else if (s[SumBits-1:16] > (SumBits-16)'(255)) begin
         result = 8'd255;
      end else begin
         result = s[23:16];
      end
      return result;
   endfunction

   always_comb begin
      yr = ProdBits'(KyR) * ProdBits'(pixel.red);
      yg = ProdBits'(KyG) * ProdBits'(pixel.green);
      yb = ProdBits'(KyB) * ProdBits'(pixel.blue);
      ur = ProdBits'(KuR) * ProdBits'(pixel.red);
      ug = ProdBits'(KuG) * ProdBits'(pixel.green);
      ub = ProdBits'(KuB) * ProdBits'(pixel.blue);
      vr = ProdBits'(KvR) * ProdBits'(pixel.red);
      vg = ProdBits'(KvG) * ProdBits'(pixel.green);
      vb = ProdBits'(KvB) * ProdBits'(pixel.blue);

      y_sum = $signed({2'b00, yr}) + $signed({2'b00, yg}) + $signed({2'b00, yb});
      u_sum = $signed({2'b00, ub}) + ChromaOfs
              - $signed({2'b00, ur}) - $signed({2'b00, ug});
      v_sum = $signed({2'b00, vr}) + ChromaOfs
              - $signed({2'b00, vg}) - $signed({2'b00, vb});
      luma     = to_byte(y_sum);
      chroma_u = to_byte(u_sum);
      chroma_v = to_byte(v_sum);
   end

endmodule

[hdl/rgb_to_yuv420_converter.sv]
// top level of the rgb to yuv 4:2:0 pixel converter
// depends on r2y_pkg, r2y_position, r2y_matrix
//
// usage:
// - req channel: one rgb pixel per beat in raster order (req_valid/req_ready,
//   payload req_pixel). rsp channel: one beat per pixel with luma, chroma u/v,
//   chroma_valid (even column and even row) and frame_end (last pixel)
// - csr port (apb style, pready tied high): frame_width at byte 0, frame_height
//   at byte 4, 13 bits each; 0 acts as 1, above 4096 acts as 4096. write only
//   while the stream is idle; a size change mid-frame keeps the counters
// - an accepted beat passes through the input register and then the result
//   register before rsp_valid rises
// - throughput: one pixel per cycle while no held rsp beat stalls the pipeline;
//   the color matrix is one combinational pass between the input register and
//   the result register. each stage has its own valid bit and takes a new beat
//   whenever it is empty or its successor moves, so a held rsp beat still lets
//   the input register fill; the block stalls req only once both stages are full
// - reset (synchronous, active high) empties the pipeline, sets the counters
//   to the top-left pixel and the sizes to 640 by 480

module rgb_to_yuv420_converter
   import r2y_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // pixel input
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_beat_type           req_pixel,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_beat_type           rsp_pixel,
   // register port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CsrAddrBits-1:0] paddr,
   input  logic [CsrDataBits-1:0] pwdata,
   output logic [CsrDataBits-1:0] prdata,
   output logic                   pready
);

   // configuration registers
   logic [SizeBits-1:0] width_ff, width_in;
   logic [SizeBits-1:0] height_ff, height_in;
   logic                csr_write;

   // pipeline stages
   logic          a_valid_ff, a_valid_in;
   req_beat_type  a_pixel_ff;
   pos_flags_type a_flags_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_beat_type  rsp_pixel_ff, rsp_pixel_in;

   logic          ready_a, out_free;
   logic          req_beat;
   pos_flags_type pos_flags;
   logic [7:0]    mat_luma, mat_u, mat_v;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (paddr[2])
            CsrFrameWidth:  width_in  = pwdata[SizeBits-1:0];
            CsrFrameHeight: height_in = pwdata[SizeBits-1:0];
            default:        width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CsrFrameWidth:  prdata = CsrDataBits'(width_ff);
         CsrFrameHeight: prdata = CsrDataBits'(height_ff);
         default:        prdata = '0;
      endcase
   end

   // stage readiness, back to front
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign ready_a   = ~a_valid_ff | out_free;
   assign req_ready = ready_a;
   assign req_beat  = req_valid & ready_a;

   // position counters advance once per accepted beat
   r2y_position u_position (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_beat),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .flags        (pos_flags)
   );

   // color matrix between the input register and the result register
   r2y_matrix u_matrix (
      .pixel    (a_pixel_ff),
      .luma     (mat_luma),
      .chroma_u (mat_u),
      .chroma_v (mat_v)
   );

   always_comb begin
      a_valid_in   = ready_a ? req_valid : a_valid_ff;
      rsp_valid_in = out_free ? a_valid_ff : rsp_valid_ff;
      rsp_pixel_in.luma         = mat_luma;
      rsp_pixel_in.chroma_u     = mat_u;
      rsp_pixel_in.chroma_v     = mat_v;
      rsp_pixel_in.chroma_valid = a_flags_ff.chroma_valid;
      rsp_pixel_in.frame_end    = a_flags_ff.frame_end;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WidthReset;
         height_ff    <= HeightReset;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         a_pixel_ff <= req_pixel;
         a_flags_ff <= pos_flags;
      end
      if (out_free & a_valid_ff) begin
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

endmodule

[hdl/r2y_checker.sv]
// port-level checks for the rgb to yuv 4:2:0 converter, bound to the top level
// depends on r2y_pkg and rgb_to_yuv420_converter

module r2y_checker
   import r2y_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_beat_type           rsp_pixel,
   input logic                   psel,
   input logic                   penable,
   input logic                   pwrite,
   input logic [CsrAddrBits-1:0] paddr,
   input logic [CsrDataBits-1:0] pwdata,
   input logic [CsrDataBits-1:0] prdata
);

   // a held result beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel))
      else $error("rsp beat changed while stalled");

   // pipeline empty after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // with no result pending every stage can take a beat
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   // a width write reads back on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
      |-> prdata[SizeBits-1:0] == $past(pwdata[SizeBits-1:0]))
      else $error("frame_width readback mismatch");

   // a height write reads back on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[2]) ##1 (psel && !pwrite && paddr[2])
      |-> prdata[SizeBits-1:0] == $past(pwdata[SizeBits-1:0]))
      else $error("frame_height readback mismatch");

endmodule

bind rgb_to_yuv420_converter r2y_checker u_r2y_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_pixel (rsp_pixel),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);
